// File: rtl/five_tuple_rule_classifier_defines.svh
// Assertion macros for the five-tuple rule classifier.
// Define ASSERT_OFF to compile them away.
`ifndef FIVE_TUPLE_RULE_CLASSIFIER_DEFINES_SVH
`define FIVE_TUPLE_RULE_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: rtl/ftrc_pkg.sv
// Package for the five-tuple rule classifier: types, codes and constants.
// No dependencies.
package ftrc_pkg;
    localparam int DEF_RULE_SLOTS = 64;

    typedef enum logic [2:0] {
        MODE_CLASSIFY = 3'd0,
        MODE_WR_SRC   = 3'd1,
        MODE_WR_DST   = 3'd2,
        MODE_WR_CTRL  = 3'd3,
        MODE_ENABLE   = 3'd4,
        MODE_REMOVE   = 3'd5,
        MODE_RD_HITS  = 3'd6,
        MODE_UNUSED   = 3'd7
    } t_mode;

    localparam logic [1:0] ACT_ACCEPT = 2'd0;
    localparam logic [1:0] ACT_REJECT = 2'd2;
    localparam logic [15:0] MAX_RANK = 16'hFFFF;

    // Item as fed to every cell of the chain
    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  rule_index;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [8:0]  protocol;
        logic [5:0]  net_len;
        logic [15:0] port_high;
        logic [1:0]  verdict;
        logic [15:0] rank;
        logic        enable;
    } t_item;

    // Running result handed from cell to cell
    typedef struct packed {
        logic        found;
        logic [15:0] best_rank;
        logic [5:0]  best_index;
        logic [1:0]  action;
        logic [31:0] hits;
        logic        live;
    } t_partial;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) m = 32'd0;
        else if (len >= 6'd32) m = 32'hFFFF_FFFF;
        else m = 32'hFFFF_FFFF << (6'd32 - len);
        return m;
    endfunction
endpackage

// File: rtl/ftrc_stream_if.sv
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface ftrc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ftrc_cell.sv
// One rule slot: stores the rule and updates the running result.
// Depends on ftrc_pkg.
module ftrc_cell
    import ftrc_pkg::*;
#(
    parameter logic [5:0] SLOT = 6'd0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_act,
    input  t_item    i_item,
    input  t_partial i_part,
    input  logic     i_hit_win,
    input  logic [5:0] i_win_index,
    output t_partial o_part
);
    logic        r_valid, r_enabled;
    logic [31:0] r_src_net, r_dst_net, r_hits;
    logic [5:0]  r_src_pre, r_dst_pre;
    logic [15:0] r_sp_lo, r_sp_hi, r_dp_lo, r_dp_hi, r_prio;
    logic [8:0]  r_proto;
    logic [1:0]  r_action;
    logic        here, match;
    logic [31:0] ms, md;
    logic [5:0]  plen;

    assign here = (i_item.rule_index == SLOT);
    assign plen = (i_item.net_len > 6'd32) ? 6'd32 : i_item.net_len;
    assign ms = prefix_mask(r_src_pre);
    assign md = prefix_mask(r_dst_pre);
    assign match = r_valid && r_enabled
        && ((i_item.src_ip & ms) == (r_src_net & ms))
        && ((i_item.dst_ip & md) == (r_dst_net & md))
        && i_item.sport >= r_sp_lo && i_item.sport <= r_sp_hi
        && i_item.dport >= r_dp_lo && i_item.dport <= r_dp_hi
        && (r_proto[8] || r_proto == i_item.protocol);

    // Fold this slot into the running result; strict less keeps lower slot
    always_comb begin
        o_part = i_part;
        if (i_item.mode == MODE_CLASSIFY && match
            && (!i_part.found || r_prio < i_part.best_rank)) begin
            o_part.found = 1'b1;
            o_part.best_rank = r_prio;
            o_part.best_index = SLOT;
            o_part.action = r_action;
        end
        if (here) begin
            o_part.live = r_valid;
            o_part.hits = r_hits;
        end
    end

    // Update rule state when the sweep of a transaction finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_enabled <= 1'b0;
            r_hits <= 32'd0;
        end else if (i_act) begin
            if (i_item.mode == MODE_CLASSIFY && i_hit_win && i_win_index == SLOT
                && r_hits != 32'hFFFF_FFFF)
                r_hits <= r_hits + 32'd1;
            if (here) begin
                case (i_item.mode)
                    MODE_WR_CTRL: begin
                        r_valid <= 1'b1;
                        r_enabled <= i_item.enable;
                        r_hits <= 32'd0;
                    end
                    MODE_ENABLE: if (r_valid) r_enabled <= i_item.enable;
                    MODE_REMOVE: begin
                        r_valid <= 1'b0;
                        r_enabled <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload fields of the rule
    always_ff @(posedge i_clk) begin
        if (i_act && here) begin
            case (i_item.mode)
                MODE_WR_SRC: begin
                    r_src_net <= i_item.src_ip;
                    r_src_pre <= plen;
                    r_sp_lo <= i_item.sport;
                    r_sp_hi <= i_item.port_high;
                end
                MODE_WR_DST: begin
                    r_dst_net <= i_item.dst_ip;
                    r_dst_pre <= plen;
                    r_dp_lo <= i_item.dport;
                    r_dp_hi <= i_item.port_high;
                end
                MODE_WR_CTRL: begin
                    r_proto <= i_item.protocol;
                    r_action <= (i_item.verdict == 2'd3) ? ACT_REJECT : i_item.verdict;
                    r_prio <= i_item.rank;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/ftrc_chain.sv
// Row of rule cells; the running result walks the row one cell per cycle.
// Depends on ftrc_pkg and ftrc_cell.
module ftrc_chain
    import ftrc_pkg::*;
#(
    parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_item    i_item,
    output logic     o_done,
    output t_partial o_part
);
    localparam int CW = $clog2(RULE_SLOTS + 1);
    t_item     r_item;
    t_partial  r_part;
    logic [CW-1:0] r_pos;
    logic      r_busy;
    t_partial  cell_out [RULE_SLOTS];
    t_partial  part_sel;
    logic      act, last;

    assign last = (r_pos == CW'(RULE_SLOTS - 1));
    // Commit state changes only when the sweep finishes
    assign act = r_busy && last;

    // Feed each cell the running result; only the output of the cell at the sweep position is kept
    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        t_partial cin;
        assign cin = r_part;
        ftrc_cell #(.SLOT(6'(g))) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_act(act),
            .i_item(r_item), .i_part(cin),
            .i_hit_win(part_sel.found), .i_win_index(part_sel.best_index),
            .o_part(cell_out[g])
        );
    end

    assign part_sel = cell_out[r_pos[$clog2(RULE_SLOTS > 1 ? RULE_SLOTS : 2)-1:0]];

    // Advance the token one slot a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= act;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pos <= '0;
            end else if (r_busy) begin
                if (last) r_busy <= 1'b0;
                else r_pos <= r_pos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
            r_part <= '0;
        end else if (r_busy) begin
            r_part <= part_sel;
        end
        if (act) o_part <= part_sel;
    end
endmodule

// File: rtl/five_tuple_rule_classifier.sv
// Five-tuple priority rule classifier.
// One input channel of t_item, one output channel of results.
// Each item sweeps the rule row one slot per cycle: the running best match
// steps through the cells, then a done flag and the result register follow
// before the result is offered.
// A new item is taken only once the last one has walked the chain of cells
// and its result has passed the output handshake.
// Every mode gives exactly one result. Classify finds the enabled valid rule
// with the lowest rank (lower slot on ties) and bumps its saturating counter;
// writes, enable, remove and hit reads address one slot by rule_index.
// Reset (synchronous, active low) clears all valid and enable marks and all
// hit counters; rule contents stay undefined until written.
// The result waits in an output register while the receiver stalls; the
// next item is taken only once that register is free, so every stall of
// the receiver delays the next item.
`include "five_tuple_rule_classifier_defines.svh"
module five_tuple_rule_classifier
    import ftrc_pkg::*;
#(
    parameter int RULE_SLOTS = DEF_RULE_SLOTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ftrc_stream_if.sink   i_in,
    ftrc_stream_if.source o_out
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic        matched;
        logic [5:0]  matched_index;
        logic [31:0] hits;
        logic        error;
    } t_res;

    t_state   r_state, n_state;
    t_item    r_item;
    t_res     r_res, n_res;
    t_partial part;
    logic     done, start;

    assign start = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data = r_res;

    ftrc_chain #(.RULE_SLOTS(RULE_SLOTS)) u_chain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_in.data),
        .o_done(done), .o_part(part)
    );

    // Sequence: take a transaction, sweep, hold the result
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_RUN;
            ST_RUN:  if (done) n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Form the result from the swept partial
    always_comb begin
        n_res = '0;
        case (r_item.mode)
            MODE_CLASSIFY: if (part.found) begin
                n_res.action = part.action;
                n_res.matched = 1'b1;
                n_res.matched_index = part.best_index;
            end
            MODE_ENABLE, MODE_REMOVE: n_res.error = !part.live;
            MODE_RD_HITS: begin
                n_res.error = !part.live;
                if (part.live) n_res.hits = part.hits;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) r_item <= i_in.data;
        if (done) r_res <= n_res;
    end

    `ASSERT_NEVER(a_ready_out, i_clk, i_rst_n, i_in.ready && o_out.valid)
    `ASSERT_CLK(a_done_run, i_clk, i_rst_n, done |-> r_state == ST_RUN)
    `ASSERT_CLK(a_start_run, i_clk, i_rst_n, start |=> r_state == ST_RUN)
endmodule
